// ----- rtl/gtva_pkg.sv -----
// ----------------------------------------------------------------------------
// gtva_pkg
// shared types and constants of the generation tagged vmid allocator
// ----------------------------------------------------------------------------
package gtva_pkg;

	localparam int VMID_W     = 14;
	localparam int VGEN_W     = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	// request function codes
	localparam logic FUNC_ENTRY = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VMID_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ID_WIDTH    = 1'b1;

	// configuration reset values
	localparam logic                  VMID_ENABLE_RST = 1'b1;
	localparam logic [CFG_DATA_W-1:0] ID_WIDTH_RST    = 4'd14;

	typedef struct packed {
		logic              func;
		logic [VGEN_W-1:0] vcpu_generation;
		logic [VMID_W-1:0] cur_vmid;
	} req_t;

	typedef struct packed {
		logic [VMID_W-1:0] vmid;
		logic [VGEN_W-1:0] new_generation;
		logic              tlb_flush;
		logic              reassigned;
	} rsp_t;

	typedef struct packed {
		logic                  vmid_enable;
		logic [CFG_DATA_W-1:0] id_width;
	} cfg_t;

endpackage

// ----- rtl/gtva_cfg.sv -----
// ----------------------------------------------------------------------------
// gtva_cfg
// configuration registers: vmid enable and implemented vmid width
// ----------------------------------------------------------------------------
module gtva_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [gtva_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [gtva_pkg::CFG_DATA_W-1:0]     wr_data,
	output gtva_pkg::cfg_t                       cfg
);

	gtva_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vmid_enable <= gtva_pkg::VMID_ENABLE_RST;
			cfg_q.id_width    <= gtva_pkg::ID_WIDTH_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				gtva_pkg::CFG_VMID_ENABLE: cfg_q.vmid_enable <= wr_data[0];
				gtva_pkg::CFG_ID_WIDTH:    cfg_q.id_width    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/gtva_core.sv -----
// ----------------------------------------------------------------------------
// gtva_core
// allocator state and the combinational next-item decision
// ----------------------------------------------------------------------------
module gtva_core #(
	parameter int GEN_WIDTH   = 64,
	parameter int MAX_ID_BITS = 14
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  gtva_pkg::cfg_t  cfg,
	input  gtva_pkg::req_t  req,
	output gtva_pkg::rsp_t  rsp
);

	localparam int ID_W  = MAX_ID_BITS + 1;
	localparam int EXT_W = (ID_W > gtva_pkg::VMID_W) ? ID_W : gtva_pkg::VMID_W;
	localparam logic [4:0] MaxLen = 5'(MAX_ID_BITS);

	logic [GEN_WIDTH-1:0] gen_q, gen_d, gen_inc, cur_gen;
	logic [ID_W-1:0]      nid_q, nid_d, max_id, id;
	logic                 act_q, act_d;
	logic [4:0]           len;
	logic                 in_use, wrap;
	logic [EXT_W-1:0]     id_ext;

	assign len = ({1'b0, cfg.id_width} > MaxLen) ? MaxLen : {1'b0, cfg.id_width};
	assign in_use  = act_q && cfg.vmid_enable && (len > 5'd1);
	assign max_id  = (ID_W'(1) << len) - ID_W'(1);
	assign gen_inc = gen_q + GEN_WIDTH'(1);
	assign wrap    = nid_q > max_id;
	assign cur_gen = wrap ? gen_inc : gen_q;
	assign id      = wrap ? ID_W'(1) : nid_q;
	assign id_ext  = EXT_W'(id);

	always_comb begin
		rsp.vmid           = req.cur_vmid;
		rsp.new_generation = req.vcpu_generation;
		rsp.tlb_flush      = 1'b0;
		rsp.reassigned     = 1'b0;
		gen_d = gen_q;
		nid_d = nid_q;
		act_d = act_q;
		if (req.func == gtva_pkg::FUNC_FLUSH) begin
			if (in_use) begin
				gen_d = gen_inc;
				if (gen_inc == '0)
					act_d = 1'b0;
			end
		end else if (!in_use) begin
			rsp.vmid = '0;
		end else if (req.vcpu_generation != gtva_pkg::VGEN_W'(gen_q)) begin
			if (wrap) begin
				gen_d = gen_inc;
				nid_d = ID_W'(1);
			end
			if (wrap && (gen_inc == '0)) begin
				// generation ran out while rolling over the ids
				act_d    = 1'b0;
				rsp.vmid = '0;
			end else begin
				nid_d              = id + ID_W'(1);
				rsp.vmid           = id_ext[gtva_pkg::VMID_W-1:0];
				rsp.new_generation = gtva_pkg::VGEN_W'(cur_gen);
				rsp.tlb_flush      = (id == ID_W'(1));
				rsp.reassigned     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= GEN_WIDTH'(1);
			nid_q <= ID_W'(1);
			act_q <= 1'b1;
		end else if (fire) begin
			gen_q <= gen_d;
			nid_q <= nid_d;
			act_q <= act_d;
		end
	end

	a_nid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		nid_q != '0) else $error("next id is zero");

	a_inactive_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		!act_q |=> !act_q) else $error("allocator reactivated without reset");

	a_active_gen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> gen_q != '0) else $error("active allocator holds generation zero");

	a_reassign_gen: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rsp.reassigned |=> gtva_pkg::VGEN_W'(gen_q) == $past(rsp.new_generation))
		else $error("issued generation differs from hart generation");

	a_flush_id_one: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rsp.tlb_flush |-> rsp.reassigned && rsp.vmid == gtva_pkg::VMID_W'(1))
		else $error("tlb flush without issuing id one");

endmodule

// ----- rtl/generation_tagged_vmid_allocator.sv -----
// ----------------------------------------------------------------------------
// generation_tagged_vmid_allocator
// per-hart round-robin vmid allocator with generation tags
// ----------------------------------------------------------------------------
// A request item is either a guest entry, which returns the vmid and
// generation the vcpu must use (a fresh id when its stored generation is
// stale), or a hart tlb flush, which advances the hart generation while
// vmids are in use. The block takes one item per clock while the result
// is not stalled; each item passes the input register, then the result
// register, and the generation compare, id increment and select in
// gtva_core are combinational between them. A result held in the result
// register by a stall keeps the next item in the input register, so the
// input stalls only while both registers are full and the result is
// stalled. There is no memory and no clearing pass after reset.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while the block is idle.
// ----------------------------------------------------------------------------
module generation_tagged_vmid_allocator #(
	parameter int GEN_WIDTH   = 64,
	parameter int MAX_ID_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                req_valid,
	output logic                                req_stall,
	input  gtva_pkg::req_t                      req,
	// result channel
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output gtva_pkg::rsp_t                      rsp,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gtva_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gtva_pkg::CFG_DATA_W-1:0]    cfg_data
);

	gtva_pkg::cfg_t cfg;
	gtva_pkg::req_t req_s1;
	logic           req_vld_s1;
	gtva_pkg::rsp_t rsp_d, rsp_q;
	logic           rsp_vld_q;
	logic           fire;

	// config registers, writes never back-pressured
	assign cfg_ready = 1'b1;

	gtva_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// the item in the input register is processed when the result register
	// is empty or its item leaves this cycle
	assign fire      = req_vld_s1 && (!rsp_vld_q || !rsp_stall);
	// input register frees up whenever its item moves on
	assign req_stall = req_vld_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			req_vld_s1 <= 1'b1;
		end else if (fire) begin
			req_vld_s1 <= 1'b0;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			req_s1 <= req;
	end

	// allocator state and decision logic
	gtva_core #(
		.GEN_WIDTH   (GEN_WIDTH),
		.MAX_ID_BITS (MAX_ID_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cfg    (cfg),
		.req    (req_s1),
		.rsp    (rsp_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (fire) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the generation tagged vmid allocator
// ----------------------------------------------------------------------------
// Guest entries and hart flushes are queued by a stimulus process and fed to
// the block by a clocked driver. At the moment each item is accepted, the
// driver runs it through a bit-accurate allocator model and queues the
// expected result. A clocked monitor checks every returned item against the
// oldest expectation. It also writes the result back into a small table of
// virtual cpus, so later entries carry the state a real hypervisor would
// hold. Both sides insert random idle cycles. Configuration is changed only
// while the block is idle.
// ----------------------------------------------------------------------------
module tb;

	localparam int GEN_WIDTH   = 64;
	localparam int MAX_ID_BITS = 14;
	localparam int NUM_VCPUS   = 8;
	localparam int PHASES      = 17;
	localparam int PHASE_ITEMS = 100;
	localparam logic [gtva_pkg::VGEN_W-1:0] GEN_MASK =
		{gtva_pkg::VGEN_W{1'b1}} >> (gtva_pkg::VGEN_W - GEN_WIDTH);

	// queued request plus the vcpu it belongs to
	typedef struct packed {
		gtva_pkg::req_t r;
		logic           tracked;
		logic [2:0]     slot;
	} pend_t;

	// expected result plus the vcpu that stores it
	typedef struct packed {
		gtva_pkg::rsp_t rsp;
		logic           tracked;
		logic [2:0]     slot;
	} want_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            req_valid = 1'b0;
	logic                            req_stall;
	gtva_pkg::req_t                  req       = '0;
	logic                            rsp_valid;
	logic                            rsp_stall = 1'b0;
	gtva_pkg::rsp_t                  rsp;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [gtva_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [gtva_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// allocator model state and its copy of the registers
	logic [gtva_pkg::VGEN_W-1:0]     hart_gen     = 64'd1;
	int unsigned                     next_free_id = 1;
	logic                            alloc_active = 1'b1;
	logic                            en_reg       = gtva_pkg::VMID_ENABLE_RST;
	logic [gtva_pkg::CFG_DATA_W-1:0] bits_reg     = gtva_pkg::ID_WIDTH_RST;

	// what each virtual cpu currently holds
	logic [gtva_pkg::VGEN_W-1:0]     vcpu_gen [NUM_VCPUS];
	logic [gtva_pkg::VMID_W-1:0]     vcpu_id  [NUM_VCPUS];

	pend_t                           req_queue [$];
	want_t                           want_rsp  [$];

	// idle control, per side
	int unsigned                     gap_max    = 0;
	int unsigned                     stall_max  = 0;
	int unsigned                     req_gap    = 0;
	int unsigned                     stall_left = 0;
	int unsigned                     errors     = 0;

	logic [2:0]                      req_slot;
	logic                            req_tracked;
	pend_t                           next_item;
	want_t                           accepted;
	want_t                           oldest;

	generation_tagged_vmid_allocator #(
		.GEN_WIDTH   (GEN_WIDTH),
		.MAX_ID_BITS (MAX_ID_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// allocator model
	// ------------------------------------------------------------------------

	// implemented id width, saturated at the widest supported
	function automatic int unsigned id_len();
		return (bits_reg > MAX_ID_BITS) ? MAX_ID_BITS : int'(bits_reg);
	endfunction

	// vmids only mean something with the allocator alive, enabled and wider than 1 bit
	function automatic logic ids_usable();
		return alloc_active && en_reg && (id_len() > 1);
	endfunction

	// generation bump; a wrap to zero kills the allocator for good
	function automatic void advance_gen();
		if (!ids_usable())
			return;
		hart_gen = (hart_gen + 1'b1) & GEN_MASK;
		if (hart_gen == '0)
			alloc_active = 1'b0;
	endfunction

	function automatic gtva_pkg::rsp_t allocate_vmid(gtva_pkg::req_t r);
		gtva_pkg::rsp_t o;
		int unsigned    max_id;
		o.vmid           = r.cur_vmid;
		o.new_generation = r.vcpu_generation;
		o.tlb_flush      = 1'b0;
		o.reassigned     = 1'b0;
		if (r.func == gtva_pkg::FUNC_FLUSH) begin
			advance_gen();
			return o;
		end
		if (!ids_usable()) begin
			o.vmid = '0;
			return o;
		end
		// vcpu still tagged with the live generation keeps its id
		if (r.vcpu_generation == hart_gen)
			return o;
		// out of ids (also after the width shrank): new generation, restart at 1
		max_id = (1 << id_len()) - 1;
		if (next_free_id > max_id) begin
			advance_gen();
			next_free_id = 1;
			if (!ids_usable()) begin
				o.vmid = '0;
				return o;
			end
		end
		o.vmid           = next_free_id[gtva_pkg::VMID_W-1:0];
		o.new_generation = hart_gen;
		o.tlb_flush      = (next_free_id == 1);
		o.reassigned     = 1'b1;
		next_free_id++;
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// request driver
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			// accepted item: predict its result right now, in order
			if (req_valid && !req_stall) begin
				accepted.rsp     = allocate_vmid(req);
				accepted.tracked = req_tracked;
				accepted.slot    = req_slot;
				want_rsp.push_back(accepted);
			end
			// slot is free after this edge: idle out the gap, then load the next item
			if (!req_valid || !req_stall) begin
				if (req_gap > 0) begin
					req_gap--;
					req_valid <= 1'b0;
				end else if (req_queue.size() > 0) begin
					next_item   = req_queue.pop_front();
					req         <= next_item.r;
					req_tracked = next_item.tracked;
					req_slot    = next_item.slot;
					req_valid   <= 1'b1;
					req_gap     = $urandom_range(0, gap_max);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// result monitor
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (want_rsp.size() == 0) begin
					$display("%0t unexpected item: vmid %0h gen %0h flush %0b reassigned %0b",
						$time, rsp.vmid, rsp.new_generation, rsp.tlb_flush, rsp.reassigned);
					errors++;
				end else begin
					oldest = want_rsp.pop_front();
					if (rsp.vmid !== oldest.rsp.vmid) begin
						$display("%0t vmid: expected %0h actual %0h",
							$time, oldest.rsp.vmid, rsp.vmid);
						errors++;
					end
					if (rsp.new_generation !== oldest.rsp.new_generation) begin
						$display("%0t new_generation: expected %0h actual %0h",
							$time, oldest.rsp.new_generation, rsp.new_generation);
						errors++;
					end
					if (rsp.tlb_flush !== oldest.rsp.tlb_flush) begin
						$display("%0t tlb_flush: expected %0b actual %0b",
							$time, oldest.rsp.tlb_flush, rsp.tlb_flush);
						errors++;
					end
					if (rsp.reassigned !== oldest.rsp.reassigned) begin
						$display("%0t reassigned: expected %0b actual %0b",
							$time, oldest.rsp.reassigned, rsp.reassigned);
						errors++;
					end
					// the vcpu stores what the allocator handed back
					if (oldest.tracked) begin
						vcpu_gen[oldest.slot] = oldest.rsp.new_generation;
						vcpu_id[oldest.slot]  = oldest.rsp.vmid;
					end
				end
				stall_left = $urandom_range(0, stall_max);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			rsp_stall <= (stall_left > 0);
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// untracked item with fixed content
	task automatic put(logic f, logic [gtva_pkg::VGEN_W-1:0] g,
		logic [gtva_pkg::VMID_W-1:0] v);
		pend_t p;
		p                   = '0;
		p.r.func            = f;
		p.r.vcpu_generation = g;
		p.r.cur_vmid        = v;
		req_queue.push_back(p);
	endtask

	// mostly vcpus re-entering with their stored state, plus flushes and noise
	task automatic add_random_item();
		pend_t       p;
		int unsigned pick;
		int unsigned s;
		p                   = '0;
		pick                = $urandom_range(0, 99);
		s                   = $urandom_range(0, NUM_VCPUS - 1);
		p.r.func            = gtva_pkg::FUNC_ENTRY;
		p.r.vcpu_generation = {$urandom, $urandom};
		p.r.cur_vmid        = gtva_pkg::VMID_W'($urandom_range(0, (1 << gtva_pkg::VMID_W) - 1));
		if (pick < 12) begin
			p.r.func = gtva_pkg::FUNC_FLUSH;
		end else if (pick < 72) begin
			p.tracked           = 1'b1;
			p.slot              = 3'(s);
			p.r.vcpu_generation = vcpu_gen[s];
			p.r.cur_vmid        = vcpu_id[s];
		end else if (pick < 84) begin
			p.r.vcpu_generation = hart_gen;
		end else if (pick < 90) begin
			p.r.vcpu_generation = '0;
		end else if (pick < 94) begin
			p.r.vcpu_generation = '1;
		end
		req_queue.push_back(p);
	endtask

	// nothing queued, nothing on the request port, nothing outstanding
	task automatic wait_idle();
		do
			@(negedge clk);
		while (req_queue.size() != 0 || req_valid || want_rsp.size() != 0);
	endtask

	// register write; only called with the block idle
	task automatic write_reg(logic [gtva_pkg::CFG_IDX_W-1:0] idx,
		logic [gtva_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == gtva_pkg::CFG_VMID_ENABLE)
			en_reg = data[0];
		else
			bits_reg = data;
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int unsigned                     ph;
		int unsigned                     sent;
		int unsigned                     n;
		int unsigned                     pick;
		logic [gtva_pkg::CFG_DATA_W-1:0] word;

		for (int i = 0; i < NUM_VCPUS; i++) begin
			vcpu_gen[i] = '0;
			vcpu_id[i]  = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: fresh vcpu gets id 1 with a tlb flush
		gap_max   = 3;
		stall_max = 3;
		@(negedge clk);
		put(gtva_pkg::FUNC_ENTRY, '0, '0);
		// generation match keeps the stored id
		put(gtva_pkg::FUNC_ENTRY, 64'd1, '1);
		put(gtva_pkg::FUNC_ENTRY, '1, 14'h2aaa);
		// hart flush passes the fields through and bumps the generation
		put(gtva_pkg::FUNC_FLUSH, '1, '1);
		put(gtva_pkg::FUNC_ENTRY, 64'd1, 14'h1555);
		put(gtva_pkg::FUNC_ENTRY, 64'd2, '0);

		// shrink to 2 bits with next id already past 3: exhausted right away
		wait_idle();
		write_reg(gtva_pkg::CFG_ID_WIDTH, 4'd2);
		@(negedge clk);
		repeat (4) put(gtva_pkg::FUNC_ENTRY, '0, 14'h3);

		// software disable: vmid 0 and the generation passes through
		wait_idle();
		write_reg(gtva_pkg::CFG_VMID_ENABLE, 4'd0);
		@(negedge clk);
		put(gtva_pkg::FUNC_ENTRY, '0, '1);
		put(gtva_pkg::FUNC_FLUSH, 64'd4, 14'h7);
		put(gtva_pkg::FUNC_ENTRY, 64'd4, 14'h7);

		// one-bit and zero-bit ids are as good as disabled
		wait_idle();
		write_reg(gtva_pkg::CFG_VMID_ENABLE, 4'd1);
		write_reg(gtva_pkg::CFG_ID_WIDTH, 4'd1);
		@(negedge clk);
		put(gtva_pkg::FUNC_ENTRY, 64'd9, 14'h9);
		put(gtva_pkg::FUNC_FLUSH, 64'd9, 14'h9);
		wait_idle();
		write_reg(gtva_pkg::CFG_ID_WIDTH, 4'd0);
		@(negedge clk);
		put(gtva_pkg::FUNC_ENTRY, '0, '0);

		// width above the maximum saturates
		wait_idle();
		write_reg(gtva_pkg::CFG_ID_WIDTH, 4'd15);
		@(negedge clk);
		put(gtva_pkg::FUNC_ENTRY, '0, '0);
		put(gtva_pkg::FUNC_ENTRY, 64'd4, 14'h2);
		put(gtva_pkg::FUNC_ENTRY, 64'h8000_0000_0000_0000, 14'h2000);

		// random phases, each with its own settings and idle profile
		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			word    = gtva_pkg::CFG_DATA_W'($urandom_range(0, (1 << gtva_pkg::CFG_DATA_W) - 1));
			word[0] = ($urandom_range(0, 9) != 0);
			write_reg(gtva_pkg::CFG_VMID_ENABLE, word);
			// small widths dominate so ids run out often
			pick = $urandom_range(0, 19);
			if (pick < 12)
				word = gtva_pkg::CFG_DATA_W'(2 + (pick % 4));
			else if (pick < 14)
				word = gtva_pkg::CFG_DATA_W'(pick - 12);
			else if (pick < 16)
				word = 4'd14;
			else if (pick < 18)
				word = 4'd15;
			else
				word = gtva_pkg::CFG_DATA_W'($urandom_range(6, 13));
			write_reg(gtva_pkg::CFG_ID_WIDTH, word);
			// every fourth phase runs back to back on both sides
			gap_max   = (ph % 4 == 3) ? 0 : 7;
			stall_max = (ph % 4 == 3) ? 0 : 7;
			sent      = 0;
			while (sent < PHASE_ITEMS) begin
				n = $urandom_range(1, 6);
				@(negedge clk);
				repeat (n) add_random_item();
				sent += n;
				while (req_queue.size() != 0)
					@(negedge clk);
				// now and then hold off until every result is back
				if ($urandom_range(0, 24) == 0)
					wait_idle();
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0 && want_rsp.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// hang guard
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
